// ----- rtl/cstk_pkg.sv -----
// Shared constants and the word-code type for the circular stack ALU.
package cstk_pkg;

  localparam int STACK_DEPTH_DEF = 8;
  localparam int WORD_BITS_DEF   = 16;
  localparam int LIT_BITS        = 16;
  localparam int OP_BITS         = 5;

  typedef enum logic [OP_BITS-1:0] {
    OP_PUSH      = 5'd0,
    OP_DUP       = 5'd1,
    OP_DROP      = 5'd2,
    OP_BACK      = 5'd3,
    OP_CLEAR     = 5'd4,
    OP_SWAP      = 5'd5,
    OP_OVER      = 5'd6,
    OP_ADD       = 5'd7,
    OP_MUL       = 5'd8,
    OP_AND       = 5'd9,
    OP_OR        = 5'd10,
    OP_XOR       = 5'd11,
    OP_INVERT    = 5'd12,
    OP_NEGATE    = 5'd13,
    OP_PRINT     = 5'd14,
    OP_PRINT_ALL = 5'd15,
    OP_NOP       = 5'd16
  } op_t;

endpackage

// ----- rtl/circular_stack_alu.sv -----
// Forth-style circular data stack with arithmetic and print words.
//
//  channel  | dir | tdata                             | tuser       | tlast
//  ---------+-----+-----------------------------------+-------------+------
//  s_*      | in  | literal_value                     | operation   | -
//  m_*      | out | top_value, emitted_value (low up) | emit_valid  | last
//
// Each word passes a single register stage; a beat is accepted every cycle while
// the output register drains and no print-all burst runs. Print-all issues
// STACK_DEPTH result beats on consecutive free output cycles, one pop each, and
// holds s_tready low until its final beat is loaded. rst clears the stack and
// the output valid. A stalled m_tready holds the result and blocks new input.
module circular_stack_alu import cstk_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int WORD_BITS   = WORD_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  input  logic [LIT_BITS-1:0]                       s_tdata,  // literal_value
  input  logic [OP_BITS-1:0]                        s_tuser,  // operation
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  output logic [((2*WORD_BITS+7)/8)*8-1:0]          m_tdata,  // top_value, emitted_value
  output logic                                      m_tuser,  // emit_valid
  output logic                                      m_tlast
);

  localparam int MDATA_BITS = ((2 * WORD_BITS + 7) / 8) * 8;
  localparam int CNT_BITS   = $clog2(STACK_DEPTH);

  logic [WORD_BITS-1:0] cells      [STACK_DEPTH];
  logic [WORD_BITS-1:0] cells_next [STACK_DEPTH];
  logic [WORD_BITS-1:0] top_value, top_value_next;
  logic [WORD_BITS-1:0] emitted_value, emitted_value_next;
  logic                 emit_valid_next;
  logic [CNT_BITS-1:0]  burst_left;
  logic                 busy, slot_free, take_in, step;
  op_t                  in_op, step_op;

  assign busy      = (burst_left != '0);
  assign slot_free = !m_tvalid || m_tready;
  assign s_tready  = slot_free && !busy;
  assign take_in   = s_tvalid && s_tready;
  assign step      = take_in || (busy && slot_free);
  assign in_op     = op_t'(s_tuser);
  assign step_op   = busy ? OP_PRINT : in_op;

  cstk_core #(
    .STACK_DEPTH (STACK_DEPTH),
    .WORD_BITS   (WORD_BITS)
  ) u_core (
    .op            (step_op),
    .literal_value (s_tdata),
    .cells         (cells),
    .cells_next    (cells_next),
    .top_value     (top_value_next),
    .emitted_value (emitted_value_next),
    .emit_valid    (emit_valid_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STACK_DEPTH; i++) cells[i] <= '0;
      m_tvalid   <= 1'b0;
      burst_left <= '0;
    end else begin
      if (step) begin
        cells    <= cells_next;
        m_tvalid <= 1'b1;
        if (busy) begin
          burst_left <= burst_left - CNT_BITS'(1);
        end else if (in_op == OP_PRINT_ALL) begin
          burst_left <= CNT_BITS'(STACK_DEPTH - 1);
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload needs no reset; load with every step.
  always_ff @(posedge clk) begin
    if (step) begin
      top_value     <= top_value_next;
      emitted_value <= emitted_value_next;
      m_tuser       <= emit_valid_next;
      if (busy) begin
        m_tlast <= (burst_left == CNT_BITS'(1));
      end else begin
        m_tlast <= (in_op != OP_PRINT_ALL);
      end
    end
  end

  assign m_tdata = MDATA_BITS'({emitted_value, top_value});

endmodule

// ----- rtl/cstk_core.sv -----
// One stack step: next cells and result fields for a word, top always at cell 0.
module cstk_core import cstk_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int WORD_BITS   = WORD_BITS_DEF
) (
  input  op_t                  op,
  input  logic [LIT_BITS-1:0]  literal_value,
  input  logic [WORD_BITS-1:0] cells      [STACK_DEPTH],
  output logic [WORD_BITS-1:0] cells_next [STACK_DEPTH],
  output logic [WORD_BITS-1:0] top_value,
  output logic [WORD_BITS-1:0] emitted_value,
  output logic                 emit_valid
);

  logic [WORD_BITS-1:0] rot_up   [STACK_DEPTH];
  logic [WORD_BITS-1:0] rot_down [STACK_DEPTH];
  logic [WORD_BITS-1:0] lit_ext;

  assign lit_ext = WORD_BITS'($signed(literal_value));

  // Cell 0 is the top; the ring rotates instead of moving a pointer.
  always_comb begin
    for (int i = 0; i < STACK_DEPTH; i++) begin
      rot_up[i]   = cells[(i + STACK_DEPTH - 1) % STACK_DEPTH];
      rot_down[i] = cells[(i + 1) % STACK_DEPTH];
    end
  end

  always_comb begin
    cells_next    = cells;
    emitted_value = '0;
    emit_valid    = 1'b0;
    case (op)
      OP_PUSH: begin
        cells_next    = rot_up;
        cells_next[0] = lit_ext;
      end
      OP_DUP: begin
        cells_next    = rot_up;
        cells_next[0] = cells[0];
      end
      OP_DROP: cells_next = rot_down;
      OP_BACK: cells_next = rot_up;
      OP_CLEAR: begin
        for (int i = 0; i < STACK_DEPTH; i++) cells_next[i] = '0;
      end
      OP_SWAP: begin
        cells_next[0] = cells[1];
        cells_next[1] = cells[0];
      end
      OP_OVER: begin
        cells_next    = rot_up;
        cells_next[0] = cells[1];
      end
      OP_ADD: begin
        cells_next    = rot_down;
        cells_next[0] = cells[0] + cells[1];
      end
      OP_MUL: begin
        cells_next    = rot_down;
        cells_next[0] = cells[0] * cells[1];
      end
      OP_AND: begin
        cells_next    = rot_down;
        cells_next[0] = cells[0] & cells[1];
      end
      OP_OR: begin
        cells_next    = rot_down;
        cells_next[0] = cells[0] | cells[1];
      end
      OP_XOR: begin
        cells_next    = rot_down;
        cells_next[0] = cells[0] ^ cells[1];
      end
      OP_INVERT: cells_next[0] = ~cells[0];
      OP_NEGATE: cells_next[0] = -cells[0];
      OP_PRINT, OP_PRINT_ALL: begin
        cells_next    = rot_down;
        emitted_value = cells[0];
        emit_valid    = 1'b1;
      end
      default: cells_next = cells;
    endcase
  end

  assign top_value = cells_next[0];

endmodule

// ----- verif/tb_top.sv -----
// Self-checking stream testbench for the circular stack ALU.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cstk_pkg::*;

  localparam int DEPTH        = STACK_DEPTH_DEF;
  localparam int WORD         = WORD_BITS_DEF;
  localparam int PTR_BITS     = $clog2(DEPTH);
  localparam int MDATA_BITS   = ((2 * WORD + 7) / 8) * 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [WORD-1:0] top_value;
    logic [WORD-1:0] emitted_value;
    logic            emit_valid;
    logic            last;
  } stack_beat_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [LIT_BITS-1:0]   s_tdata  = '0;  // literal_value
  logic [OP_BITS-1:0]    s_tuser  = '0;  // operation
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [MDATA_BITS-1:0] m_tdata;        // top_value, emitted_value
  logic                  m_tuser;        // emit_valid
  logic                  m_tlast;

  // Shadow copy of the stack and the results it predicts
  logic [WORD-1:0]     shadow_cells [DEPTH];
  logic [PTR_BITS-1:0] shadow_tos;
  stack_beat_t         stack_results_q [$];

  bit idle_enable     = 1'b1;
  int error_count     = 0;
  int words_sent      = 0;
  int beats_checked   = 0;
  int print_all_count = 0;
  int cycle_count     = 0;

  circular_stack_alu i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) shadow_cells[i] = '0;
    shadow_tos = '0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected", cycle_count,
               stack_results_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  task automatic push_cell(input logic [WORD-1:0] v);
    shadow_tos = shadow_tos + 1'b1;
    shadow_cells[shadow_tos] = v;
  endtask

  task automatic pop_cell(output logic [WORD-1:0] v);
    v = shadow_cells[shadow_tos];
    shadow_tos = shadow_tos - 1'b1;
  endtask

  task automatic note_result(input logic [WORD-1:0] emitted, input logic valid,
                             input logic last);
    stack_beat_t r;
    r.top_value     = shadow_cells[shadow_tos];
    r.emitted_value = valid ? emitted : '0;
    r.emit_valid    = valid;
    r.last          = last;
    stack_results_q.push_back(r);
  endtask

  task automatic step_stack(input logic [OP_BITS-1:0] op, input logic [LIT_BITS-1:0] lit);
    logic [WORD-1:0] a;
    logic [WORD-1:0] b;
    case (op)
      OP_PUSH:   push_cell(WORD'($signed(lit)));
      OP_DUP:    push_cell(shadow_cells[shadow_tos]);
      OP_DROP:   pop_cell(a);
      OP_BACK:   shadow_tos = shadow_tos + 1'b1;
      OP_CLEAR:  for (int i = 0; i < DEPTH; i++) shadow_cells[i] = '0;
      OP_SWAP: begin
        pop_cell(a);
        pop_cell(b);
        push_cell(a);
        push_cell(b);
      end
      OP_OVER: begin
        pop_cell(a);
        pop_cell(b);
        push_cell(b);
        push_cell(a);
        push_cell(b);
      end
      OP_ADD: begin
        pop_cell(a);
        shadow_cells[shadow_tos] = a + shadow_cells[shadow_tos];
      end
      OP_MUL: begin
        pop_cell(a);
        shadow_cells[shadow_tos] = a * shadow_cells[shadow_tos];
      end
      OP_AND: begin
        pop_cell(a);
        shadow_cells[shadow_tos] = a & shadow_cells[shadow_tos];
      end
      OP_OR: begin
        pop_cell(a);
        shadow_cells[shadow_tos] = a | shadow_cells[shadow_tos];
      end
      OP_XOR: begin
        pop_cell(a);
        shadow_cells[shadow_tos] = a ^ shadow_cells[shadow_tos];
      end
      OP_INVERT: shadow_cells[shadow_tos] = ~shadow_cells[shadow_tos];
      OP_NEGATE: shadow_cells[shadow_tos] = '0 - shadow_cells[shadow_tos];
      OP_PRINT: begin
        pop_cell(a);
        note_result(a, 1'b1, 1'b1);
      end
      OP_PRINT_ALL: begin
        print_all_count++;
        for (int i = 0; i < DEPTH; i++) begin
          pop_cell(a);
          note_result(a, 1'b1, i == DEPTH - 1);
        end
      end
      default: ;
    endcase
    if (op != OP_PRINT && op != OP_PRINT_ALL) note_result('0, 1'b0, 1'b1);
  endtask

  // ------------------------------------------------------------ stream sides

  task automatic send_word(input logic [OP_BITS-1:0] op, input logic [LIT_BITS-1:0] lit);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= lit;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
    step_stack(op, lit);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_beat
    stack_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (stack_results_q.size() == 0) begin
        $error("result beat with nothing expected: tdata=%h tuser=%b tlast=%b",
               m_tdata, m_tuser, m_tlast);
        error_count++;
      end else begin
        want = stack_results_q.pop_front();
        beats_checked++;
        if (m_tdata[WORD-1:0] !== want.top_value) begin
          $error("top_value expected %h actual %h", want.top_value, m_tdata[WORD-1:0]);
          error_count++;
        end
        if (m_tdata[2*WORD-1:WORD] !== want.emitted_value) begin
          $error("emitted_value expected %h actual %h", want.emitted_value,
                 m_tdata[2*WORD-1:WORD]);
          error_count++;
        end
        if (m_tuser !== want.emit_valid) begin
          $error("emit_valid expected %b actual %b", want.emit_valid, m_tuser);
          error_count++;
        end
        if (m_tlast !== want.last) begin
          $error("last expected %b actual %b", want.last, m_tlast);
          error_count++;
        end
      end
    end
  end

  // ------------------------------------------------------------------ tests

  task automatic test_reset_contents();
    // wrap once round the cleared stack
    send_word(OP_PRINT_ALL, 16'h5a5a);
  endtask

  task automatic test_stack_words();
    send_word(OP_PUSH, 16'h7fff);
    send_word(OP_PUSH, 16'h0001);
    send_word(OP_DUP, 16'hffff);
    send_word(OP_PUSH, 16'h8000);
    send_word(OP_PUSH, 16'h1234);
    send_word(OP_SWAP, 16'h0000);
    send_word(OP_OVER, 16'h0000);
    send_word(OP_DROP, 16'h0000);
    send_word(OP_BACK, 16'h0000);
  endtask

  task automatic test_alu_words();
    send_word(OP_ADD, 16'h0000);
    send_word(OP_MUL, 16'h0000);
    send_word(OP_AND, 16'h0000);
    send_word(OP_OR, 16'h0000);
    send_word(OP_XOR, 16'h0000);
    send_word(OP_INVERT, 16'h0000);
    send_word(OP_PUSH, 16'h8000);
    // negating the most negative word wraps to itself
    send_word(OP_NEGATE, 16'h0000);
    send_word(OP_PUSH, 16'h7fff);
    send_word(OP_ADD, 16'h0000);
  endtask

  task automatic test_print_and_unused();
    send_word(OP_PRINT, 16'h0000);
    send_word(OP_NOP, 16'hffff);
    send_word(OP_BITS'(OP_NOP + 1), 16'h0000);
    send_word(OP_BITS'((1 << OP_BITS) - 1), 16'hffff);
    send_word(OP_PRINT_ALL, 16'h0000);
    send_word(OP_CLEAR, 16'h0000);
    send_word(OP_PRINT, 16'h0000);
  endtask

  task automatic test_random_words(input int count);
    int               r;
    logic [OP_BITS-1:0] op;
    logic [LIT_BITS-1:0] lit;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 5) op = OP_BITS'($urandom_range(OP_NOP + 1, (1 << OP_BITS) - 1));
      else if (r < 9) op = OP_PRINT_ALL;
      else if (r < 30) op = OP_PUSH;
      else op = OP_BITS'($urandom_range(OP_PUSH, OP_NOP));
      r = $urandom_range(0, 9);
      case (r)
        0: lit = 16'h8000;
        1: lit = 16'h7fff;
        2: lit = 16'hffff;
        3: lit = 16'h0000;
        default: lit = LIT_BITS'($urandom_range(0, (1 << LIT_BITS) - 1));
      endcase
      send_word(op, lit);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_contents();
    test_stack_words();
    test_alu_words();
    test_print_and_unused();
    test_random_words(273);
    // finish with back-to-back beats on both sides
    idle_enable = 1'b0;
    test_random_words(70);
    s_tvalid <= 1'b0;
    while (stack_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (stack_results_q.size() != 0) begin
      $error("%0d expected beats never arrived", stack_results_q.size());
      error_count++;
    end
    $display("Sent %0d stack words (%0d print-all bursts), checked %0d result beats.",
             words_sent, print_all_count, beats_checked);
    $display("Mismatches seen: %0d", error_count);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- circular_stack_alu.f -----
rtl/cstk_pkg.sv
rtl/cstk_core.sv
rtl/circular_stack_alu.sv
verif/tb_top.sv
